FILE: sv/htsd_pkg.sv
// Shared types and constants for the depth and age replacement position table.
package htsd_pkg;

	localparam int unsigned TABLE_ENTRIES = 65536;
	localparam int unsigned SLOT_W        = $clog2(TABLE_ENTRIES);

	localparam int unsigned KEY_W   = 64;
	localparam int unsigned DEPTH_W = 8;
	localparam int unsigned SCORE_W = 21;
	localparam int unsigned BOUND_W = 2;
	localparam int unsigned MOVE_W  = 32;
	localparam int unsigned AGE_W   = 8;
	localparam int unsigned IDX_W   = 16;
	localparam int unsigned ACT_W   = 3;

	localparam int unsigned S_DATA_W = 128;
	localparam int unsigned M_DATA_W = 24;

	localparam logic signed [SCORE_W-1:0] SCORE_HI = 21'sd900000;
	localparam logic signed [SCORE_W-1:0] SCORE_LO = -21'sd900000;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [ACT_W-1:0] {
		ACT_REJECT   = 3'd0,
		ACT_REWRITE  = 3'd1,
		ACT_AGE_ONLY = 3'd2,
		ACT_REPLACE  = 3'd3,
		ACT_KEEP     = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_EVAL
	} back_state_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [DEPTH_W-1:0] depth;
		logic [SCORE_W-1:0] score;
		logic [BOUND_W-1:0] bound;
		logic [MOVE_W-1:0]  move;
		logic               reject;
	} req_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [DEPTH_W-1:0] depth;
		logic [SCORE_W-1:0] score;
		logic [BOUND_W-1:0] bound;
		logic [MOVE_W-1:0]  move;
		logic [AGE_W-1:0]   age;
	} entry_t;

	typedef struct packed {
		logic clearing;
	} bk_stat_t;

	typedef struct packed {
		logic [IDX_W-1:0] slot;
		action_t          action;
	} res_t;

endpackage

FILE: sv/htsd_front.sv
// Front end: accept store requests, screen the score, queue them for the table.
module htsd_front import htsd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic [BOUND_W-1:0]  s_tuser,
	input  bk_stat_t            bk_stat,
	output logic                q_valid,
	output req_t                q_req,
	input  logic                q_pop
);

	req_t              queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;
	req_t              req;
	logic signed [SCORE_W-1:0] score;

	always_comb begin
		score      = s_tdata[92:72];
		req.key    = s_tdata[63:0];
		req.depth  = s_tdata[71:64];
		req.score  = s_tdata[92:72];
		req.bound  = s_tuser;
		req.move   = s_tdata[124:93];
		req.reject = (score > SCORE_HI) || (score < SCORE_LO);
	end

	assign s_tready = !bk_stat.clearing && (cnt_q != QCNT_W'(QUEUE_DEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (cnt_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_req    = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/htsd_back.sv
// Back end: table memory, read-modify-write sequencer and result register.
module htsd_back import htsd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [AGE_W-1:0] search_age,
	input  logic             q_valid,
	input  req_t             q_req,
	output logic             q_pop,
	output bk_stat_t         bk_stat,
	output logic             out_valid,
	output res_t             out_res,
	input  logic             out_ready
);

	entry_t             slot_mem [TABLE_ENTRIES];
	back_state_t        state_q;
	back_state_t        state_d;
	logic [SLOT_W-1:0]  clr_cnt_q;
	req_t               req_q;
	entry_t             rd_q;
	logic               out_vld_q;
	res_t               out_res_q;

	logic               mem_we;
	logic               mem_re;
	logic [SLOT_W-1:0]  mem_addr;
	entry_t             mem_wdata;
	logic               load_out;
	action_t            act;
	logic               match;
	logic               deeper;
	entry_t             new_entry;
	entry_t             aged_entry;

	always_comb begin
		match  = (rd_q.key == req_q.key);
		deeper = (req_q.depth >= rd_q.depth);

		new_entry.key   = req_q.key;
		new_entry.depth = req_q.depth;
		new_entry.score = req_q.score;
		new_entry.bound = req_q.bound;
		new_entry.move  = req_q.move;
		new_entry.age   = search_age;

		aged_entry     = rd_q;
		aged_entry.age = search_age;

		priority if (req_q.reject) begin
			act = ACT_REJECT;
		end else if (match && deeper) begin
			act = ACT_REWRITE;
		end else if (match) begin
			act = ACT_AGE_ONLY;
		end else if ((rd_q.key == '0) || (rd_q.age != search_age) || deeper) begin
			act = ACT_REPLACE;
		end else begin
			act = ACT_KEEP;
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = req_q.key[SLOT_W-1:0];
		mem_wdata = new_entry;
		q_pop     = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			BK_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_cnt_q;
				mem_wdata = '0;
				if (clr_cnt_q == {SLOT_W{1'b1}}) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				mem_addr = q_req.key[SLOT_W-1:0];
				if (q_valid) begin
					mem_re  = 1'b1;
					q_pop   = 1'b1;
					state_d = BK_EVAL;
				end
			end
			BK_EVAL: begin
				if (!out_vld_q || out_ready) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
					unique case (act)
						ACT_REWRITE, ACT_REPLACE: begin
							mem_we    = 1'b1;
							mem_wdata = new_entry;
						end
						ACT_AGE_ONLY: begin
							mem_we    = 1'b1;
							mem_wdata = aged_entry;
						end
						default: begin
							mem_we = 1'b0;
						end
					endcase
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= slot_mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			req_q <= q_req;
		end
		if (load_out) begin
			out_res_q.slot   <= IDX_W'(req_q.key[SLOT_W-1:0]);
			out_res_q.action <= act;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_CLEAR;
			clr_cnt_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign bk_stat.clearing = (state_q == BK_CLEAR);
	assign out_valid        = out_vld_q;
	assign out_res          = out_res_q;

endmodule

FILE: sv/hash_table_store_depth_age_replace.sv
// Top level of the direct-mapped position table store with depth and age replacement.
// Flow: an accepted request is queued; BK_IDLE reads its slot from the single-port table,
// BK_EVAL decides the action, writes back and registers the result, then the next request
// is read; the 2-entry request queue and result register let each side stall alone.
// Reset: control clears at once; a clearing pass then zeroes all TABLE_ENTRIES slots,
// one per cycle, with s_tready low; cfg writes are taken throughout.
module hash_table_store_depth_age_replace import htsd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [AGE_W-1:0]    cfg_wdata,    // search_age
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,      // position_key, search_depth, score, best_move, pad
	input  logic [BOUND_W-1:0]  s_tuser,      // bound_kind
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata       // action, slot_index, pad
);

	logic [AGE_W-1:0] search_age_q;
	bk_stat_t         bk_stat;
	logic             q_valid;
	req_t             q_req;
	logic             q_pop;
	res_t             out_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_age_q <= '0;
		end else if (cfg_we) begin
			search_age_q <= cfg_wdata;
		end
	end

	htsd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.bk_stat  (bk_stat),
		.q_valid  (q_valid),
		.q_req    (q_req),
		.q_pop    (q_pop)
	);

	htsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.search_age (search_age_q),
		.q_valid    (q_valid),
		.q_req      (q_req),
		.q_pop      (q_pop),
		.bk_stat    (bk_stat),
		.out_valid  (m_tvalid),
		.out_res    (out_res),
		.out_ready  (m_tready)
	);

	assign m_tdata = {(M_DATA_W - IDX_W - ACT_W)'(0), out_res.slot, out_res.action};

	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.clearing |-> !s_tready)
		else $error("request accepted during table clear");

	a_no_result_clear: assert property (@(posedge clk) disable iff (!arst_n)
		bk_stat.clearing |-> !m_tvalid)
		else $error("result offered during table clear");

	a_pop_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("back end popped an empty queue");

endmodule
